### sv/sfs_pkg.sv
// Types, register indexes and the control store for the sprite frame sequencer.
// Depends on nothing; every other file in the project imports it.
`timescale 1ns / 1ps
`default_nettype none

package sfs_pkg;

	// Payload words.
	typedef struct packed {
		logic        op;
		logic [23:0] delta_time;
		logic        restart_backward;
	} item_t;

	typedef struct packed {
		logic [7:0] frame_index;
		logic [7:0] atlas_row;
		logic [7:0] atlas_col;
		logic       done_res;
	} result_t;

	localparam logic OP_TICK    = 1'b0;
	localparam logic OP_RESTART = 1'b1;

	// Configuration register indexes.
	localparam logic [2:0] CFG_FRAME_TOTAL   = 3'd0;
	localparam logic [2:0] CFG_FRAME_PERIOD  = 3'd1;
	localparam logic [2:0] CFG_LOOP_ENABLE   = 3'd2;
	localparam logic [2:0] CFG_PINGPONG      = 3'd3;
	localparam logic [2:0] CFG_ATLAS_COLUMNS = 3'd4;

	localparam int PC_W     = 4;
	localparam int DIV_BITS = 8;

	typedef logic [PC_W-1:0] pc_t;

	typedef enum logic [2:0] {
		UOP_NOP,
		UOP_WAIT,
		UOP_SUB,
		UOP_ADVANCE,
		UOP_RESTART,
		UOP_DIV_LOAD,
		UOP_DIV_STEP,
		UOP_EMIT
	} uop_t;

	typedef enum logic [2:0] {
		COND_NEVER,
		COND_ALWAYS,
		COND_NO_ITEM,
		COND_RESTART,
		COND_NOT_DUE,
		COND_DIV_MORE,
		COND_OUT_FREE
	} cond_t;

	typedef struct packed {
		uop_t  uop;
		cond_t cond;
		pc_t   target;
	} ucode_t;

	// Divider control from the sequencer.
	typedef struct packed {
		logic load;
		logic step;
	} div_ctl_t;

	// Program addresses.
	localparam pc_t PC_WAIT    = 4'd0;
	localparam pc_t PC_DECODE  = 4'd1;
	localparam pc_t PC_SUB     = 4'd2;
	localparam pc_t PC_TEST    = 4'd3;
	localparam pc_t PC_ADVANCE = 4'd4;
	localparam pc_t PC_RESTART = 4'd5;
	localparam pc_t PC_DLOAD   = 4'd6;
	localparam pc_t PC_DSTEP   = 4'd7;
	localparam pc_t PC_EMIT    = 4'd8;
	localparam pc_t PC_HOLD    = 4'd9;

	// A taken jump goes to target; otherwise the step counter moves on by one.
	function automatic ucode_t ucode_rom(input pc_t pc);
		ucode_t w;
		case (pc)
			PC_WAIT:    w = '{UOP_WAIT,     COND_NO_ITEM,  PC_WAIT};
			PC_DECODE:  w = '{UOP_NOP,      COND_RESTART,  PC_RESTART};
			PC_SUB:     w = '{UOP_SUB,      COND_NEVER,    PC_WAIT};
			PC_TEST:    w = '{UOP_NOP,      COND_NOT_DUE,  PC_WAIT};
			PC_ADVANCE: w = '{UOP_ADVANCE,  COND_ALWAYS,   PC_DLOAD};
			PC_RESTART: w = '{UOP_RESTART,  COND_NEVER,    PC_WAIT};
			PC_DLOAD:   w = '{UOP_DIV_LOAD, COND_NEVER,    PC_WAIT};
			PC_DSTEP:   w = '{UOP_DIV_STEP, COND_DIV_MORE, PC_DSTEP};
			PC_EMIT:    w = '{UOP_EMIT,     COND_OUT_FREE, PC_WAIT};
			PC_HOLD:    w = '{UOP_NOP,      COND_ALWAYS,   PC_EMIT};
			default:    w = '{UOP_NOP,      COND_ALWAYS,   PC_WAIT};
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

### sv/sfs_div.sv
// Restoring divider, one quotient bit per step, for the atlas row and column.
// Depends on sfs_pkg for the control struct and the step count.
`timescale 1ns / 1ps
`default_nettype none

module sfs_div (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire sfs_pkg::div_ctl_t ctl,
	input  wire logic [7:0]       dividend,
	input  wire logic [8:0]       divisor,
	output logic [7:0]            quotient,
	output logic [7:0]            remainder,
	output logic                  more
);
	import sfs_pkg::*;

	logic [7:0] quo_q;
	logic [8:0] rem_q;
	logic [3:0] cnt_q;
	logic [9:0] trial;
	logic       fits;

	assign trial = {rem_q, quo_q[7]};
	assign fits  = trial >= {1'b0, divisor};

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (ctl.step) begin
			quo_q <= {quo_q[6:0], fits};
			// The remainder stays below the divisor, so nine bits hold it.
			rem_q <= fits ? 9'(trial - {1'b0, divisor}) : trial[8:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctl.load) begin
			cnt_q <= 4'(DIV_BITS);
		end else if (ctl.step && cnt_q != '0) begin
			cnt_q <= cnt_q - 4'd1;
		end
	end

	// More steps remain after the one being taken now.
	assign more      = cnt_q > 4'd1;
	assign quotient  = quo_q;
	assign remainder = rem_q[7:0];

endmodule

`default_nettype wire

### sv/sprite_frame_sequencer.sv
// Top level of the sprite frame sequencer: microcoded control, countdown and
// frame stepping datapath. Depends on sfs_pkg and sfs_div.
//
//  channel | direction | handshake          | word
//  item    | in        | item_valid/stall   | sfs_pkg::item_t
//  res     | out       | res_valid/stall    | sfs_pkg::result_t
//  cfg     | in        | cfg_valid/ready    | cfg_index, cfg_data
//
// One item at a time. A tick that is not yet due returns to wait; a tick that
// steps and a restart both run through the serial divider before emit step.
// A stalled result holds the sequencer at the emit step until it is taken.
// Reset clears the countdown, frame position, direction and completed flag
// and loads the register defaults. Both input channels hold off during reset;
// otherwise cfg is always ready.
`timescale 1ns / 1ps
`default_nettype none

module sprite_frame_sequencer #(
	parameter int MAX_FRAMES = 256
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             item_valid,
	output logic                  item_stall,
	input  wire sfs_pkg::item_t   item,
	output logic                  res_valid,
	input  wire logic             res_stall,
	output sfs_pkg::result_t      res,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [2:0]       cfg_index,
	input  wire logic [23:0]      cfg_data
);
	import sfs_pkg::*;

	localparam logic [8:0] POS_LIM = 9'((MAX_FRAMES < 256) ? MAX_FRAMES : 256);

	// Configuration registers.
	logic [8:0]  frame_total_q;
	logic [23:0] frame_period_q;
	logic        loop_q;
	logic        pingpong_q;
	logic [8:0]  columns_q;

	// Captured item.
	logic        op_q;
	logic [23:0] delta_q;
	logic        back_req_q;

	// Animation state.
	logic signed [24:0] countdown_q;
	logic [7:0]         pos_q;
	logic               going_back_q;
	logic               finished_q;

	pc_t      pc_q;
	pc_t      pc_next;
	ucode_t   uw;
	logic     take;
	logic     out_free;
	logic     accept;
	div_ctl_t div_ctl;
	logic [7:0] quotient;
	logic [7:0] remainder;
	logic       div_more;
	logic       res_valid_q;
	result_t    res_q;

	logic [8:0] total;
	logic [7:0] last_pos;
	logic [7:0] adv_pos;
	logic       adv_back;
	logic       adv_fin;
	logic signed [24:0] cd_sub;
	logic signed [24:0] cd_add;

	function automatic logic signed [24:0] sat25(input logic signed [25:0] v);
		logic signed [24:0] r;
		if (v > 26'sd16777215) begin
			r = 25'sd16777215;
		end else if (v < -26'sd16777216) begin
			r = -25'sd16777216;
		end else begin
			r = v[24:0];
		end
		return r;
	endfunction

	assign uw       = ucode_rom(pc_q);
	assign out_free = !res_valid_q || !res_stall;
	assign accept   = item_valid && !item_stall;

	// Next step.
	always_comb begin
		case (uw.cond)
			COND_NEVER:    take = 1'b0;
			COND_ALWAYS:   take = 1'b1;
			COND_NO_ITEM:  take = !item_valid;
			COND_RESTART:  take = op_q == OP_RESTART;
			COND_NOT_DUE:  take = !countdown_q[24] && countdown_q != '0;
			COND_DIV_MORE: take = div_more;
			COND_OUT_FREE: take = out_free;
			default:       take = 1'b1;
		endcase
		pc_next = take ? uw.target : pc_q + pc_t'(1);
	end

	// Control word decode.
	always_comb begin
		item_stall   = uw.uop != UOP_WAIT || !arst_n;
		div_ctl.load = uw.uop == UOP_DIV_LOAD;
		div_ctl.step = uw.uop == UOP_DIV_STEP;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_WAIT;
		end else begin
			pc_q <= pc_next;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q       <= item.op;
			delta_q    <= item.delta_time;
			back_req_q <= item.restart_backward;
		end
	end

	assign cfg_ready = arst_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_total_q  <= 9'd2;
			frame_period_q <= 24'd65536;
			loop_q         <= 1'b0;
			pingpong_q     <= 1'b0;
			columns_q      <= 9'd0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_FRAME_TOTAL:   frame_total_q  <= cfg_data[8:0];
				CFG_FRAME_PERIOD:  frame_period_q <= cfg_data;
				CFG_LOOP_ENABLE:   loop_q         <= cfg_data[0];
				CFG_PINGPONG:      pingpong_q     <= cfg_data[0];
				CFG_ATLAS_COLUMNS: columns_q      <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	// Effective frame total, clamped to the supported range.
	always_comb begin
		if (frame_total_q < 9'd2) begin
			total = 9'd2;
		end else if (frame_total_q > POS_LIM) begin
			total = POS_LIM;
		end else begin
			total = frame_total_q;
		end
		last_pos = 8'(total - 9'd1);
	end

	assign cd_sub = sat25({countdown_q[24], countdown_q} - {2'b00, delta_q});
	assign cd_add = sat25({countdown_q[24], countdown_q} + {2'b00, frame_period_q});

	// One frame step in the current direction.
	always_comb begin
		adv_pos  = pos_q;
		adv_back = going_back_q;
		adv_fin  = finished_q;
		if (going_back_q) begin
			if (pos_q != 8'd0) begin
				adv_pos = pos_q - 8'd1;
			end else if (loop_q && pingpong_q) begin
				adv_back = 1'b0;
				adv_pos  = 8'd1;
			end else if (loop_q) begin
				adv_pos = last_pos;
			end else begin
				adv_fin = 1'b1;
				adv_pos = 8'd0;
			end
		end else begin
			if ({1'b0, pos_q} + 9'd1 < total) begin
				adv_pos = pos_q + 8'd1;
			end else if (pingpong_q) begin
				adv_back = 1'b1;
				adv_pos  = 8'(total - 9'd2);
			end else if (loop_q) begin
				adv_pos = 8'd0;
			end else begin
				adv_fin = 1'b1;
				adv_pos = last_pos;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			countdown_q  <= '0;
			pos_q        <= '0;
			going_back_q <= 1'b0;
			finished_q   <= 1'b0;
		end else begin
			case (uw.uop)
				UOP_SUB: begin
					countdown_q <= cd_sub;
				end
				UOP_ADVANCE: begin
					countdown_q  <= cd_add;
					pos_q        <= adv_pos;
					going_back_q <= adv_back;
					finished_q   <= adv_fin;
				end
				UOP_RESTART: begin
					finished_q   <= 1'b0;
					going_back_q <= back_req_q;
					pos_q        <= back_req_q ? last_pos : 8'd0;
				end
				default: ;
			endcase
		end
	end

	sfs_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (div_ctl),
		.dividend  (pos_q),
		.divisor   (columns_q),
		.quotient  (quotient),
		.remainder (remainder),
		.more      (div_more)
	);

	// Output register: the emit step loads it only once the previous word has gone.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (uw.uop == UOP_EMIT && out_free) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (uw.uop == UOP_EMIT && out_free) begin
			res_q.frame_index <= pos_q;
			res_q.atlas_row   <= (columns_q == 9'd0) ? 8'd0 : quotient;
			res_q.atlas_col   <= (columns_q == 9'd0) ? 8'd0 : remainder;
			res_q.done_res    <= finished_q;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

`default_nettype wire

### sim/sfs_frame_checker.sv
// Scoreboard for the sprite frame sequencer: watches the item, result and config channels,
// predicts each result word from its own copy of the sequencer state and compares them.
// Depends on sfs_pkg for the word types, op codes and register indexes.
`timescale 1ns / 1ps

module sfs_frame_checker #(
	parameter int MAX_FRAMES = 256
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	input  logic             item_stall,
	input  sfs_pkg::item_t   item,
	input  logic             res_valid,
	input  logic             res_stall,
	input  sfs_pkg::result_t res,
	input  logic             cfg_valid,
	input  logic             cfg_ready,
	input  logic [2:0]       cfg_index,
	input  logic [23:0]      cfg_data,
	output int               pending,
	output int               failures
);
	import sfs_pkg::*;

	localparam longint COUNT_MAX = 64'sd16777215;
	localparam longint COUNT_MIN = -64'sd16777216;
	localparam int TOTAL_CAP = (MAX_FRAMES < 256) ? MAX_FRAMES : 256;

	// Shadow registers.
	logic [8:0]  total_reg;
	logic [23:0] period_reg;
	logic        loop_reg;
	logic        pingpong_reg;
	logic [8:0]  columns_reg;

	// Shadow animation state.
	longint      countdown;
	logic [7:0]  pos;
	logic        reversing;
	logic        done_flag;

	result_t     expected_frames[$];
	int          mismatches;

	function automatic logic [8:0] clamped_total();
		if (total_reg < 9'd2)
			return 9'd2;
		if (int'(total_reg) > TOTAL_CAP)
			return 9'(TOTAL_CAP);
		return total_reg;
	endfunction

	function automatic longint saturate(input longint v);
		if (v > COUNT_MAX)
			return COUNT_MAX;
		if (v < COUNT_MIN)
			return COUNT_MIN;
		return v;
	endfunction

	// Returns 1 when the word produces a result frame, which is placed in r.
	function automatic bit predict_frame(input item_t w, output result_t r);
		logic [8:0] span;
		span = clamped_total();
		r = '0;
		if (w.op == OP_RESTART) begin
			done_flag = 1'b0;
			reversing = w.restart_backward;
			pos = w.restart_backward ? 8'(span - 9'd1) : 8'd0;
		end else begin
			countdown = saturate(countdown - longint'(w.delta_time));
			if (countdown > 0)
				return 1'b0;
			countdown = saturate(countdown + longint'(period_reg));
			// Only one step per tick, however late the tick is.
			if (reversing) begin
				if (pos != 8'd0) begin
					pos = pos - 8'd1;
				end else if (loop_reg && pingpong_reg) begin
					reversing = 1'b0;
					pos = 8'd1;
				end else if (loop_reg) begin
					pos = 8'(span - 9'd1);
				end else begin
					done_flag = 1'b1;
					pos = 8'd0;
				end
			end else begin
				if ({1'b0, pos} + 9'd1 < span) begin
					pos = pos + 8'd1;
				end else if (pingpong_reg) begin
					reversing = 1'b1;
					pos = 8'(span - 9'd2);
				end else if (loop_reg) begin
					pos = 8'd0;
				end else begin
					done_flag = 1'b1;
					pos = 8'(span - 9'd1);
				end
			end
		end
		r.frame_index = pos;
		if (columns_reg != 9'd0) begin
			r.atlas_row = 8'({1'b0, pos} / columns_reg);
			r.atlas_col = 8'({1'b0, pos} % columns_reg);
		end
		r.done_res = done_flag;
		return 1'b1;
	endfunction

	function automatic int field_differs(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0d, actual %0d", name, want, got);
			return 1;
		end
		return 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		result_t guess;
		if (!arst_n) begin
			total_reg    = 9'd2;
			period_reg   = 24'd65536;
			loop_reg     = 1'b0;
			pingpong_reg = 1'b0;
			columns_reg  = 9'd0;
			countdown    = 0;
			pos          = 8'd0;
			reversing    = 1'b0;
			done_flag    = 1'b0;
			mismatches   = 0;
			expected_frames.delete();
		end else begin
			if (res_valid && !res_stall) begin
				if (expected_frames.size() == 0) begin
					$error("result word with nothing expected: index %0d row %0d col %0d done %0d",
						res.frame_index, res.atlas_row, res.atlas_col, res.done_res);
					mismatches = mismatches + 1;
				end else begin
					want = expected_frames.pop_front();
					mismatches = mismatches
						+ field_differs("frame_index", want.frame_index, res.frame_index)
						+ field_differs("atlas_row", want.atlas_row, res.atlas_row)
						+ field_differs("atlas_col", want.atlas_col, res.atlas_col)
						+ field_differs("done_res", 8'(want.done_res), 8'(res.done_res));
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_FRAME_TOTAL:   total_reg = cfg_data[8:0];
					CFG_FRAME_PERIOD:  period_reg = cfg_data;
					CFG_LOOP_ENABLE:   loop_reg = cfg_data[0];
					CFG_PINGPONG:      pingpong_reg = cfg_data[0];
					CFG_ATLAS_COLUMNS: columns_reg = cfg_data[8:0];
					default: ;
				endcase
			end
			if (item_valid && !item_stall) begin
				if (predict_frame(item, guess))
					expected_frames.push_back(guess);
			end
		end
		// Nonblocking so the top always reads a settled value.
		pending  <= expected_frames.size();
		failures <= mismatches;
	end

endmodule

### sim/sprite_frame_sequencer_test.sv
// Top of the sprite frame sequencer testbench: clock, reset, item and config stimulus,
// random result stalls and the final verdict. Depends on sfs_pkg, the sequencer RTL
// and sfs_frame_checker, which does all prediction and comparison.
`timescale 1ns / 1ps

module sprite_frame_sequencer_test;
	import sfs_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int RANDOM_ITEMS = 950;
	localparam int QUIET_CYCLES = 24;
	localparam int HOLD_CYCLES  = 300;

	logic        clk;
	logic        arst_n;
	logic        item_valid;
	logic        item_stall;
	item_t       item;
	logic        res_valid;
	logic        res_stall;
	result_t     res;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [23:0] cfg_data;
	int          pending;
	int          failures;

	int          cycles = 0;
	bit          calm = 1'b0;
	int          hold_asks = 0;
	logic [23:0] cur_period = 24'd65536;
	int          sent_items = 0;

	sprite_frame_sequencer uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res        (res),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	sfs_frame_checker frame_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res        (res),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.pending    (pending),
		.failures   (failures)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Result side: random stalls, a quiet stretch on request and a long hold-off.
	initial begin : receiver
		int served;
		served = 0;
		res_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_asks != served) begin
				served = served + 1;
				res_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				res_stall <= 1'b0;
			end else if (calm) begin
				res_stall <= 1'b0;
			end else begin
				res_stall <= ($urandom_range(99) < 10);
			end
		end
	end

	function automatic item_t make_word(input logic op, input logic [23:0] delta,
			input logic back);
		item_t w;
		w.op = op;
		w.delta_time = delta;
		w.restart_backward = back;
		return w;
	endfunction

	function automatic item_t random_word(input logic [23:0] per);
		item_t w;
		int pick;
		w.op = ($urandom_range(99) < 10) ? OP_RESTART : OP_TICK;
		w.restart_backward = 1'($urandom_range(1));
		pick = $urandom_range(99);
		// Mostly deltas around one period so that frames step often.
		if (pick < 70 && per <= 24'h7FFFFF)
			w.delta_time = 24'($urandom_range(0, 2 * int'(per) + 1));
		else if (pick < 78)
			w.delta_time = 24'd0;
		else if (pick < 84)
			w.delta_time = 24'hFFFFFF;
		else
			w.delta_time = 24'($urandom);
		return w;
	endfunction

	// Sometimes sets the bits above a register's width, which must be ignored.
	function automatic logic [23:0] junk_above(input logic [23:0] v, input int w);
		logic [23:0] keep;
		keep = (24'd1 << w) - 24'd1;
		if ($urandom_range(3) == 0)
			return v | (24'($urandom) & ~keep);
		return v;
	endfunction

	task automatic push_item(input item_t w);
		item <= w;
		item_valid <= 1'b1;
		do @(posedge clk); while (item_stall);
		if (!calm && $urandom_range(99) < 10) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 20)) @(posedge clk);
		end
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [23:0] data);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic load_settings(input logic [8:0] total, input logic [23:0] per,
			input logic lp, input logic pp, input logic [8:0] cols);
		write_reg(CFG_FRAME_TOTAL, junk_above({15'd0, total}, 9));
		write_reg(CFG_FRAME_PERIOD, per);
		write_reg(CFG_LOOP_ENABLE, junk_above({23'd0, lp}, 1));
		write_reg(CFG_PINGPONG, junk_above({23'd0, pp}, 1));
		write_reg(CFG_ATLAS_COLUMNS, junk_above({15'd0, cols}, 9));
		cur_period = per;
	endtask

	// Stop offering words and wait until the sequencer has nothing left in flight.
	task automatic drain();
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	task automatic random_phase(input int phase);
		logic [8:0]  total;
		logic [23:0] per;
		logic [8:0]  cols;
		int count;
		if (phase == 0) begin
			load_settings(9'd2, 24'd0, 1'b0, 1'b0, 9'd0);
		end else if (phase == 1) begin
			load_settings(9'd511, 24'hFFFFFF, 1'b1, 1'b1, 9'd511);
		end else begin
			case ($urandom_range(5))
				0: total = 9'd2;
				1: total = 9'd256;
				2: total = 9'($urandom_range(511));
				default: total = 9'($urandom_range(3, 8));
			endcase
			case ($urandom_range(5))
				0: per = 24'd0;
				1: per = 24'd1;
				2: per = 24'hFFFFFF;
				3: per = 24'd65536;
				default: per = 24'($urandom_range(1, 100000));
			endcase
			case ($urandom_range(5))
				0: cols = 9'd0;
				1: cols = 9'd1;
				2: cols = 9'd256;
				3: cols = 9'($urandom_range(257, 511));
				default: cols = 9'($urandom_range(2, 16));
			endcase
			load_settings(total, per, 1'($urandom_range(1)), 1'($urandom_range(1)), cols);
		end
		calm = (phase == 2);
		count = $urandom_range(50, 90);
		for (int i = 0; i < count; i++) begin
			// Let the result side hold off while words keep coming.
			if (phase == 3 && i == 10)
				hold_asks = hold_asks + 1;
			// Pause the sender until every result is in.
			if (phase == 4 && i == 20)
				drain();
			push_item(random_word(cur_period));
			sent_items = sent_items + 1;
		end
		calm = 1'b0;
		drain();
	endtask

	initial begin
		int phase;
		arst_n = 1'b0;
		item_valid <= 1'b0;
		item <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_FRAME_TOTAL;
		cfg_data <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: zero and full-scale deltas, the latter twice to pin the
		// countdown at its lower bound, then both kinds of restart.
		push_item(make_word(OP_TICK, 24'd0, 1'b0));
		push_item(make_word(OP_TICK, 24'hFFFFFF, 1'b0));
		push_item(make_word(OP_TICK, 24'hFFFFFF, 1'b1));
		push_item(make_word(OP_RESTART, 24'd0, 1'b0));
		push_item(make_word(OP_RESTART, 24'hFFFFFF, 1'b1));
		drain();

		// Zero period: every tick steps, play out to completion and step past the end.
		load_settings(9'd3, 24'd0, 1'b0, 1'b0, 9'd0);
		push_item(make_word(OP_RESTART, 24'd0, 1'b0));
		push_item(make_word(OP_TICK, 24'd7, 1'b0));
		push_item(make_word(OP_TICK, 24'd0, 1'b0));
		push_item(make_word(OP_TICK, 24'd1, 1'b0));
		push_item(make_word(OP_TICK, 24'd3, 1'b0));
		drain();

		// Shrink the total under the current index, then step forward.
		write_reg(CFG_FRAME_TOTAL, 24'd2);
		push_item(make_word(OP_TICK, 24'd0, 1'b0));
		drain();

		// Total above the limit is clamped; columns beyond 256 divide plainly.
		load_settings(9'd511, 24'hFFFFFF, 1'b1, 1'b1, 9'd300);
		push_item(make_word(OP_RESTART, 24'd0, 1'b1));
		push_item(make_word(OP_TICK, 24'hFFFFFF, 1'b0));
		push_item(make_word(OP_RESTART, 24'd0, 1'b0));
		push_item(make_word(OP_TICK, 24'd0, 1'b0));
		drain();

		// Total below the minimum, looping ping-pong turning at both ends.
		load_settings(9'd0, 24'd1, 1'b1, 1'b1, 9'd1);
		push_item(make_word(OP_RESTART, 24'd0, 1'b1));
		push_item(make_word(OP_TICK, 24'hFFFFFF, 1'b0));
		push_item(make_word(OP_TICK, 24'hFFFFFF, 1'b0));
		push_item(make_word(OP_TICK, 24'hFFFFFF, 1'b0));
		drain();

		load_settings(9'd256, 24'd65536, 1'b1, 1'b0, 9'd256);
		push_item(make_word(OP_RESTART, 24'd0, 1'b1));
		push_item(make_word(OP_TICK, 24'hFFFFFF, 1'b0));
		push_item(make_word(OP_RESTART, 24'd0, 1'b0));
		drain();

		phase = 0;
		while (sent_items < RANDOM_ITEMS) begin
			random_phase(phase);
			phase = phase + 1;
		end

		drain();
		repeat (40) @(posedge clk);
		if (failures == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
